>>> hdl/slwl_pkg.sv
package slwl_pkg;

  // sizing of the flow table, the per-flow log and the time stamps
  localparam int FLOW_COUNT = 64;
  localparam int LOG_DEPTH  = 16;
  localparam int TIME_BITS  = 32;

  // fixed port widths
  localparam int FLOW_IN_W = 6;
  localparam int TIME_IN_W = 32;
  localparam int CFG_W     = 32;
  localparam int LIM_IN_W  = 5;
  localparam int OUT_CNT_W = 5;
  localparam int RETRY_W   = 32;

  // derived widths
  localparam int FLOW_W      = (FLOW_COUNT > 1) ? $clog2(FLOW_COUNT) : 1;
  localparam int IDX_W       = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
  localparam int CNT_W       = $clog2(LOG_DEPTH + 1);
  localparam int LIM_W       = (CNT_W > LIM_IN_W) ? CNT_W : LIM_IN_W;
  localparam int SLOT_W      = CNT_W + 1;
  localparam int STAMP_DEPTH = FLOW_COUNT * LOG_DEPTH;
  localparam int SA_W        = (STAMP_DEPTH > 1) ? $clog2(STAMP_DEPTH) : 1;
  localparam int AW          = ((TIME_BITS > CFG_W) ? TIME_BITS : CFG_W) + 1;

  // time mask and retry saturation value on the arithmetic width
  localparam logic [AW-1:0] TIME_MASK_AW = (AW'(1) << TIME_BITS) - AW'(1);
  localparam logic [AW-1:0] OUT_MASK_AW  = (AW'(1) << RETRY_W) - AW'(1);
  localparam logic [AW-1:0] RETRY_CAP    = (TIME_BITS < RETRY_W) ? TIME_MASK_AW : OUT_MASK_AW;

  typedef enum logic [2:0] {
    S_IDLE,
    S_REC,
    S_EXP,
    S_RETRY,
    S_FIN
  } state_t;

  typedef enum logic {
    REQ_CHECK = 1'b0,
    REQ_CLEAR = 1'b1
  } req_t;

  typedef enum logic [0:0] {
    CFG_WINDOW  = 1'b0,
    CFG_MAX_REQ = 1'b1
  } cfg_idx_t;

  typedef enum logic {
    OP_AGE,
    OP_RETRY
  } alu_op_t;

  // per-flow log record
  typedef struct packed {
    logic [IDX_W-1:0] head;
    logic [CNT_W-1:0] count;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  // request to the shared time unit
  typedef struct packed {
    alu_op_t       op;
    logic [AW-1:0] now;
    logic [AW-1:0] stamp;
    logic [AW-1:0] window;
  } alu_req_t;

  // answer of the shared time unit
  typedef struct packed {
    logic               flag;
    logic [RETRY_W-1:0] value;
  } alu_rsp_t;

  // flow index wrapped onto the table
  function automatic logic [FLOW_W-1:0] wrap_flow(input logic [FLOW_IN_W-1:0] f);
    return FLOW_W'(32'(f) % FLOW_COUNT);
  endfunction

  // address of one log slot in the stamp memory
  function automatic logic [SA_W-1:0] stamp_addr(input logic [FLOW_W-1:0] f,
                                                 input logic [IDX_W-1:0] idx);
    return SA_W'(f) * SA_W'(LOG_DEPTH) + SA_W'(idx);
  endfunction

endpackage

>>> hdl/slwl_ram.sv
module slwl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/slwl_alu.sv
module slwl_alu
  import slwl_pkg::*;
(
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  logic [AW-1:0] age;
  logic [AW-1:0] ahead;
  logic [AW-1:0] ahead_sum;
  logic [AW-1:0] left;
  logic [AW-1:0] retry;
  logic          stamp_ahead;

  // age of a stamp, zero when the stamp lies in the future
  assign stamp_ahead = req.stamp >= req.now;
  assign age         = stamp_ahead ? '0 : (req.now - req.stamp);

  // time until the oldest live stamp leaves the window, saturated
  assign ahead     = req.stamp - req.now;
  assign ahead_sum = ahead + req.window;
  assign left      = req.window - age;

  always_comb begin
    if (stamp_ahead) begin
      retry = (ahead_sum > RETRY_CAP) ? RETRY_CAP : ahead_sum;
    end else begin
      retry = (left > RETRY_CAP) ? RETRY_CAP : left;
    end
  end

  // flag: stamp has expired; value: retry time or age
  always_comb begin
    rsp.flag = age > req.window;
    case (req.op)
      OP_RETRY: rsp.value = RETRY_W'(retry);
      OP_AGE:   rsp.value = RETRY_W'(age);
      default:  rsp.value = '0;
    endcase
  end

endmodule

>>> hdl/sliding_window_log_rate_limiter.sv
// channel  direction  handshake             payload
// in       input      in_valid / in_ready   req_type, flow_id, current_time
// out      output     out_valid / out_ready allowed, remaining, live_total, retry_wait
// cfg      input      cfg_we                cfg_index, cfg_data
//
// a check item reads the flow record, pops the expired stamps, works out the retry
// time when denied with a live log, and ends in the final step; a clear item skips both
// the single stamp memory read port sets the pace: one stamp is tested per cycle
// reset clears the flow valid bits at once, so there is no clearing pass
// a waiting result holds the block in its final step until out_ready
module sliding_window_log_rate_limiter
  import slwl_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 req_type,
  input  logic [FLOW_IN_W-1:0] flow_id,
  input  logic [TIME_IN_W-1:0] current_time,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 allowed,
  output logic [OUT_CNT_W-1:0] remaining,
  output logic [OUT_CNT_W-1:0] live_total,
  output logic [RETRY_W-1:0]   retry_wait,
  input  logic                 cfg_we,
  input  logic [0:0]           cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  state_t state;
  state_t state_next;

  logic [CFG_W-1:0]    window_length;
  logic [LIM_IN_W-1:0] request_cap;

  logic                req_clear;
  logic [FLOW_W-1:0]   flow;
  logic [AW-1:0]       now;
  logic [IDX_W-1:0]    head;
  logic [CNT_W-1:0]    count;
  logic [IDX_W-1:0]    slot;
  logic                append;
  logic [FLOW_COUNT-1:0] flow_valid;

  logic                 res_allowed;
  logic [OUT_CNT_W-1:0] res_remaining;
  logic [OUT_CNT_W-1:0] res_total;
  logic [RETRY_W-1:0]   res_retry;

  // memory ports
  logic                 rec_we;
  logic                 rec_re;
  logic [FLOW_W-1:0]    rec_raddr;
  logic [REC_W-1:0]     rec_rdata;
  rec_t                 rec_wr;
  rec_t                 rec_rd;
  logic                 stamp_we;
  logic                 stamp_re;
  logic [SA_W-1:0]      stamp_raddr;
  logic [SA_W-1:0]      stamp_waddr;
  logic [TIME_BITS-1:0] stamp_rdata;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  logic [FLOW_W-1:0] flow_in;
  logic [IDX_W-1:0]  rec_head;
  logic [CNT_W-1:0]  rec_count;
  logic [LIM_W-1:0]  lim_req;
  logic [LIM_W-1:0]  limit;
  logic [LIM_W-1:0]  count_l;
  logic [IDX_W-1:0]  head_inc;
  logic [SLOT_W-1:0] slot_sum;
  logic [IDX_W-1:0]  slot_calc;
  logic              pop;
  logic              deny;
  logic              out_free;
  logic              fin_go;

  assign flow_in = wrap_flow(flow_id);

  // record as read, a flow that is not valid reads as empty
  assign rec_rd    = rec_t'(rec_rdata);
  assign rec_head  = flow_valid[flow] ? rec_rd.head : '0;
  assign rec_count = !flow_valid[flow] ? '0 :
                     (rec_rd.count > CNT_W'(LOG_DEPTH)) ? CNT_W'(LOG_DEPTH) : rec_rd.count;

  // effective limit, saturated at the log depth
  assign lim_req = LIM_W'(request_cap);
  assign limit   = (lim_req > LIM_W'(LOG_DEPTH)) ? LIM_W'(LOG_DEPTH) : lim_req;
  assign count_l = LIM_W'(count);
  assign deny    = count_l >= limit;

  // ring index arithmetic
  assign head_inc  = (head == IDX_W'(LOG_DEPTH - 1)) ? '0 : head + IDX_W'(1);
  assign slot_sum  = SLOT_W'(head) + SLOT_W'(count);
  assign slot_calc = (slot_sum >= SLOT_W'(LOG_DEPTH)) ?
                     IDX_W'(slot_sum - SLOT_W'(LOG_DEPTH)) : IDX_W'(slot_sum);

  // expiry test on the stamp just read
  assign pop = (count != '0) && alu_rsp.flag;

  assign out_free = !out_valid || out_ready;
  assign fin_go   = (state == S_FIN) && out_free;
  assign in_ready = state == S_IDLE;

  // shared time unit
  always_comb begin
    alu_req.op     = (state == S_RETRY) ? OP_RETRY : OP_AGE;
    alu_req.now    = now;
    alu_req.stamp  = AW'(stamp_rdata);
    alu_req.window = AW'(window_length);
  end

  slwl_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_REC;
        end
      end
      S_REC: begin
        state_next = req_clear ? S_FIN : S_EXP;
      end
      S_EXP: begin
        if (pop) begin
          state_next = S_EXP;
        end else if (deny && (count != '0)) begin
          state_next = S_RETRY;
        end else begin
          state_next = S_FIN;
        end
      end
      S_RETRY: begin
        state_next = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // memory control
  always_comb begin
    rec_re      = 1'b0;
    rec_raddr   = flow_in;
    rec_we      = 1'b0;
    stamp_re    = 1'b0;
    stamp_raddr = stamp_addr(flow, rec_head);
    stamp_we    = 1'b0;
    stamp_waddr = stamp_addr(flow, slot);
    rec_wr.head  = head;
    rec_wr.count = count;
    case (state)
      S_IDLE: begin
        rec_re = in_valid;
      end
      S_REC: begin
        stamp_re = !req_clear && (rec_count != '0);
      end
      S_EXP: begin
        stamp_re    = pop;
        stamp_raddr = stamp_addr(flow, head_inc);
      end
      S_FIN: begin
        rec_we   = fin_go && !req_clear;
        stamp_we = fin_go && append;
      end
      default: begin
      end
    endcase
  end

  slwl_ram #(
    .WIDTH (REC_W),
    .DEPTH (FLOW_COUNT)
  ) u_rec_ram (
    .clk   (clk),
    .we    (rec_we),
    .waddr (flow),
    .wdata (rec_wr),
    .re    (rec_re),
    .raddr (rec_raddr),
    .rdata (rec_rdata)
  );

  slwl_ram #(
    .WIDTH (TIME_BITS),
    .DEPTH (STAMP_DEPTH)
  ) u_stamp_ram (
    .clk   (clk),
    .we    (stamp_we),
    .waddr (stamp_waddr),
    .wdata (TIME_BITS'(now)),
    .re    (stamp_re),
    .raddr (stamp_raddr),
    .rdata (stamp_rdata)
  );

  // control state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      window_length <= CFG_W'(1000);
      request_cap   <= LIM_IN_W'(10);
      flow_valid    <= '0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          CFG_WINDOW:  window_length <= cfg_data;
          CFG_MAX_REQ: request_cap   <= cfg_data[LIM_IN_W-1:0];
          default: begin
          end
        endcase
      end
      if (fin_go) begin
        flow_valid[flow] <= !req_clear;
      end
      if (fin_go) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // item datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          req_clear <= req_type == REQ_CLEAR;
          flow      <= flow_in;
          now       <= AW'(current_time) & TIME_MASK_AW;
          append    <= 1'b0;
        end
      end
      S_REC: begin
        head <= rec_head;
        count <= rec_count;
        if (req_clear) begin
          res_allowed   <= 1'b1;
          res_remaining <= '0;
          res_total     <= '0;
          res_retry     <= '0;
        end
      end
      S_EXP: begin
        if (pop) begin
          head  <= head_inc;
          count <= count - CNT_W'(1);
        end else begin
          res_total <= OUT_CNT_W'(count_l);
          res_retry <= '0;
          if (deny) begin
            res_allowed   <= 1'b0;
            res_remaining <= '0;
          end else begin
            res_allowed   <= 1'b1;
            res_remaining <= OUT_CNT_W'(limit - count_l - LIM_W'(1));
            append        <= 1'b1;
            slot          <= slot_calc;
            count         <= count + CNT_W'(1);
          end
        end
      end
      S_RETRY: begin
        res_retry <= alu_rsp.value;
      end
      default: begin
      end
    endcase
    // result register
    if (fin_go) begin
      allowed    <= res_allowed;
      remaining  <= res_remaining;
      live_total <= res_total;
      retry_wait <= res_retry;
    end
  end

endmodule

>>> test/sliding_window_log_rate_limiter_test.sv
module sliding_window_log_rate_limiter_test
  import slwl_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 3000;
  localparam int TAIL_CYCLES = 40;
  localparam int IDLE_PCT    = 18;
  localparam int DRILLS      = 23;
  localparam int PLANS       = 9;

  // one verdict of the limiter
  typedef struct packed {
    logic                 allowed;
    logic [OUT_CNT_W-1:0] quota_left;
    logic [OUT_CNT_W-1:0] live;
    logic [RETRY_W-1:0]   retry;
  } decision_t;

  // one directed row: limit settings, the request, and an optional hand-typed verdict
  typedef struct packed {
    logic [CFG_W-1:0]     win;
    logic [LIM_IN_W-1:0]  cap;
    req_t                 kind;
    logic [FLOW_IN_W-1:0] flow;
    logic [TIME_IN_W-1:0] stamp;
    logic                 typed;
    decision_t            want;
  } drill_t;

  // one random phase: limit settings, item count, and whether idling is off
  typedef struct packed {
    logic [CFG_W-1:0]    win;
    logic [LIM_IN_W-1:0] cap;
    int                  n;
    logic                calm;
  } limit_plan_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  req_t                 req_type = REQ_CHECK;
  logic [FLOW_IN_W-1:0] flow_id = '0;
  logic [TIME_IN_W-1:0] current_time = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 allowed;
  logic [OUT_CNT_W-1:0] remaining;
  logic [OUT_CNT_W-1:0] live_total;
  logic [RETRY_W-1:0]   retry_wait;
  logic                 cfg_we = 1'b0;
  logic [0:0]           cfg_index = CFG_WINDOW;
  logic [CFG_W-1:0]     cfg_data = '0;

  // shadow of the flow logs and the limit registers
  logic [TIME_IN_W-1:0] stamp_log [FLOW_COUNT][LOG_DEPTH];
  int unsigned          log_head [FLOW_COUNT];
  int unsigned          log_count [FLOW_COUNT];
  logic [CFG_W-1:0]     win_len = 32'd1000;
  logic [LIM_IN_W-1:0]  req_cap = 5'd10;

  decision_t pending_verdicts [$];
  logic      calm = 1'b0;
  int        mismatches = 0;
  int        items_sent = 0;
  int        results_seen = 0;
  int        denials = 0;
  int        clears = 0;
  int        back_steps = 0;
  int        settings_used = 0;
  int        quiet_cycles = 0;

  drill_t drills [DRILLS] = '{
    // reset limits: window 1000, ten requests
    '{32'd1000, 5'd10, REQ_CHECK, 6'd0, 32'd100, 1'b1, '{1'b1, 5'd9, 5'd0, 32'd0}},
    '{32'd1000, 5'd10, REQ_CHECK, 6'd0, 32'd100, 1'b1, '{1'b1, 5'd8, 5'd1, 32'd0}},
    '{32'd1000, 5'd10, REQ_CLEAR, 6'd0, 32'd200, 1'b1, '{1'b1, 5'd0, 5'd0, 32'd0}},
    '{32'd1000, 5'd10, REQ_CHECK, 6'd0, 32'd200, 1'b1, '{1'b1, 5'd9, 5'd0, 32'd0}},
    '{32'd1000, 5'd10, REQ_CHECK, 6'd63, 32'hFFFF_FFFF, 1'b1, '{1'b1, 5'd9, 5'd0, 32'd0}},
    '{32'd1000, 5'd10, REQ_CHECK, 6'd63, 32'd300, 1'b1, '{1'b1, 5'd8, 5'd1, 32'd0}},
    '{32'd1000, 5'd10, REQ_CHECK, 6'd62, 32'h8000_0000, 1'b0, '0},
    // zero limit: empty log, live log, and a stamp from the future at the head
    '{32'd1000, 5'd0, REQ_CHECK, 6'd5, 32'd1000, 1'b1, '{1'b0, 5'd0, 5'd0, 32'd0}},
    '{32'd1000, 5'd0, REQ_CHECK, 6'd0, 32'd1000, 1'b1, '{1'b0, 5'd0, 5'd1, 32'd200}},
    '{32'd1000, 5'd0, REQ_CHECK, 6'd63, 32'd1000, 1'b1,
      '{1'b0, 5'd0, 5'd2, 32'hFFFF_FFFF}},
    // limit above the log depth saturates at sixteen
    '{32'hFFFF_FFFF, 5'd31, REQ_CLEAR, 6'd10, 32'd0, 1'b1, '{1'b1, 5'd0, 5'd0, 32'd0}},
    '{32'hFFFF_FFFF, 5'd31, REQ_CHECK, 6'd10, 32'd50, 1'b1, '{1'b1, 5'd15, 5'd0, 32'd0}},
    // widest window: retry near the top, then saturated when time steps back
    '{32'hFFFF_FFFF, 5'd1, REQ_CHECK, 6'd10, 32'd60, 1'b1,
      '{1'b0, 5'd0, 5'd1, 32'hFFFF_FFF5}},
    '{32'hFFFF_FFFF, 5'd1, REQ_CHECK, 6'd10, 32'd40, 1'b1,
      '{1'b0, 5'd0, 5'd1, 32'hFFFF_FFFF}},
    // zero window keeps only stamps equal to now
    '{32'd0, 5'd2, REQ_CHECK, 6'd20, 32'd500, 1'b1, '{1'b1, 5'd1, 5'd0, 32'd0}},
    '{32'd0, 5'd2, REQ_CHECK, 6'd20, 32'd500, 1'b1, '{1'b1, 5'd0, 5'd1, 32'd0}},
    '{32'd0, 5'd2, REQ_CHECK, 6'd20, 32'd501, 1'b1, '{1'b1, 5'd1, 5'd0, 32'd0}},
    '{32'd0, 5'd2, REQ_CHECK, 6'd20, 32'd501, 1'b1, '{1'b1, 5'd0, 5'd1, 32'd0}},
    '{32'd0, 5'd2, REQ_CHECK, 6'd20, 32'd501, 1'b1, '{1'b0, 5'd0, 5'd2, 32'd0}},
    // smallest window, full depth limit
    '{32'd1, 5'd16, REQ_CHECK, 6'd33, 32'd1000, 1'b1, '{1'b1, 5'd15, 5'd0, 32'd0}},
    '{32'd1, 5'd16, REQ_CHECK, 6'd33, 32'd1001, 1'b1, '{1'b1, 5'd14, 5'd1, 32'd0}},
    '{32'd1, 5'd16, REQ_CHECK, 6'd33, 32'd1002, 1'b1, '{1'b1, 5'd14, 5'd1, 32'd0}},
    '{32'd1, 5'd16, REQ_CHECK, 6'd33, 32'd1003, 1'b0, '0}
  };

  limit_plan_t plans [PLANS] = '{
    '{32'd1000, 5'd10, 150, 1'b0},
    '{32'd60, 5'd3, 150, 1'b1},
    '{32'd1, 5'd1, 120, 1'b0},
    '{32'd0, 5'd2, 120, 1'b0},
    '{32'd400, 5'd16, 160, 1'b0},
    '{32'hFFFF_FFFF, 5'd5, 120, 1'b0},
    '{32'd150, 5'd31, 160, 1'b0},
    '{32'd500, 5'd0, 80, 1'b0},
    '{32'd7, 5'd4, 110, 1'b0}
  };

  sliding_window_log_rate_limiter u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .req_type     (req_type),
    .flow_id      (flow_id),
    .current_time (current_time),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .allowed      (allowed),
    .remaining    (remaining),
    .live_total   (live_total),
    .retry_wait   (retry_wait),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // expire old stamps, then grant or deny and update the flow log
  function automatic decision_t limiter_decide(input req_t kind,
                                               input logic [FLOW_IN_W-1:0] flow,
                                               input logic [TIME_IN_W-1:0] stamp);
    decision_t       d;
    int unsigned     fl, hd, cnt, lim, slot;
    longint unsigned t_now, oldest, ahead, wl, cap, tmask;
    d = '0;
    tmask = (TIME_BITS >= 32) ? 64'hFFFF_FFFF : ((64'd1 << TIME_BITS) - 64'd1);
    cap = tmask;
    fl = flow % FLOW_COUNT;
    t_now = 64'(stamp) & tmask;
    wl = 64'(win_len);
    lim = (32'(req_cap) > LOG_DEPTH) ? LOG_DEPTH : 32'(req_cap);
    if (kind == REQ_CLEAR) begin
      log_head[fl] = 0;
      log_count[fl] = 0;
      d.allowed = 1'b1;
      return d;
    end
    hd = log_head[fl] % LOG_DEPTH;
    cnt = (log_count[fl] > LOG_DEPTH) ? LOG_DEPTH : log_count[fl];
    // pop from the oldest end until a live stamp shows up
    while (cnt > 0) begin
      oldest = 64'(stamp_log[fl][hd]);
      if (t_now > oldest && t_now - oldest > wl) begin
        hd = (hd + 1) % LOG_DEPTH;
        cnt--;
      end else begin
        break;
      end
    end
    d.live = OUT_CNT_W'(cnt);
    if (cnt >= lim) begin
      // denied: time until the oldest live stamp leaves the window
      if (cnt > 0) begin
        oldest = 64'(stamp_log[fl][hd]);
        if (oldest >= t_now) begin
          ahead = oldest - t_now;
          d.retry = (ahead > cap || wl > cap - ahead) ? RETRY_W'(cap) : RETRY_W'(ahead + wl);
        end else begin
          ahead = wl - (t_now - oldest);
          d.retry = (ahead > cap) ? RETRY_W'(cap) : RETRY_W'(ahead);
        end
      end
    end else begin
      slot = (hd + cnt) % LOG_DEPTH;
      stamp_log[fl][slot] = TIME_IN_W'(t_now);
      d.allowed = 1'b1;
      d.quota_left = OUT_CNT_W'(lim - cnt - 1);
      cnt++;
    end
    log_head[fl] = hd;
    log_count[fl] = cnt;
    return d;
  endfunction

  task automatic note_mismatch(input string what, input longint unsigned got,
                               input longint unsigned want);
    mismatches++;
    $display("mismatch %0d at %0t ns: %s got 0x%0h want 0x%0h", mismatches, $realtime,
             what, got, want);
  endtask

  // hold off the sender until every verdict is back and the block is idle
  task automatic settle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_verdicts.size() != 0 || !in_ready) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic apply_limits(input logic [CFG_W-1:0] w, input logic [LIM_IN_W-1:0] m);
    settle();
    cfg_we <= 1'b1;
    cfg_index <= CFG_WINDOW;
    cfg_data <= w;
    @(posedge clk);
    cfg_index <= CFG_MAX_REQ;
    cfg_data <= CFG_W'(m);
    @(posedge clk);
    cfg_we <= 1'b0;
    win_len = w;
    req_cap = m;
    settings_used++;
  endtask

  // offer one item, predict its verdict at the accepting edge
  task automatic send_request(input req_t kind, input logic [FLOW_IN_W-1:0] flow,
                              input logic [TIME_IN_W-1:0] stamp, input logic typed,
                              input decision_t want);
    decision_t d;
    if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < IDLE_PCT);
    end
    in_valid <= 1'b1;
    req_type <= kind;
    flow_id <= flow;
    current_time <= stamp;
    do @(posedge clk); while (!in_ready);
    d = limiter_decide(kind, flow, stamp);
    if (typed)
      d = want;
    pending_verdicts = {pending_verdicts, d};
    items_sent++;
    if (kind == REQ_CLEAR)
      clears++;
  endtask

  // result stall pattern
  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // compare each result with the oldest prediction
  always @(posedge clk) begin : check_results
    decision_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (pending_verdicts.size() == 0) begin
        note_mismatch("result with no request pending", 64'(allowed), 64'd0);
      end else begin
        want = pending_verdicts.pop_front();
        if (allowed !== want.allowed)
          note_mismatch("allowed", 64'(allowed), 64'(want.allowed));
        if (remaining !== want.quota_left)
          note_mismatch("remaining", 64'(remaining), 64'(want.quota_left));
        if (live_total !== want.live)
          note_mismatch("live_total", 64'(live_total), 64'(want.live));
        if (retry_wait !== want.retry)
          note_mismatch("retry_wait", 64'(retry_wait), 64'(want.retry));
        if (want.allowed == 1'b0)
          denials++;
      end
    end
  end

  // give up when neither channel moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned          span, roll;
    logic [TIME_IN_W-1:0] t_cur;
    logic [FLOW_IN_W-1:0] hot [4];
    logic [FLOW_IN_W-1:0] fl;
    req_t                 kind;
    for (int f = 0; f < FLOW_COUNT; f++) begin
      log_head[f] = 0;
      log_count[f] = 0;
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed rows, limits rewritten whenever a row asks for new ones
    foreach (drills[k]) begin
      if (drills[k].win != win_len || drills[k].cap != req_cap)
        apply_limits(drills[k].win, drills[k].cap);
      send_request(drills[k].kind, drills[k].flow, drills[k].stamp, drills[k].typed,
                   drills[k].want);
    end

    // random phases: a few hot flows with bursts, plus scattered flows and time jumps
    foreach (plans[p]) begin
      apply_limits(plans[p].win, plans[p].cap);
      calm = plans[p].calm;
      for (int h = 0; h < 4; h++)
        hot[h] = FLOW_IN_W'($urandom_range(0, FLOW_COUNT - 1));
      t_cur = (p % 3 == 2) ? $urandom : $urandom_range(0, 5000);
      span = (plans[p].win > 4000) ? 4000 : plans[p].win;
      for (int i = 0; i < plans[p].n; i++) begin
        fl = ($urandom_range(0, 99) < 75) ? hot[$urandom_range(0, 3)]
                                          : FLOW_IN_W'($urandom_range(0, FLOW_COUNT - 1));
        kind = ($urandom_range(0, 99) < 5) ? REQ_CLEAR : REQ_CHECK;
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
          t_cur = t_cur - $urandom_range(0, span + 1);
          back_steps++;
        end else if (roll < 5) begin
          t_cur = $urandom;
        end else if (roll < 55) begin
          t_cur = t_cur + $urandom_range(0, span / 32 + 1);
        end else if (roll < 95) begin
          t_cur = t_cur + $urandom_range(0, span / 4 + 1);
        end else begin
          t_cur = t_cur + $urandom_range(0, 2 * span + 2);
        end
        if (i == plans[p].n / 2 || $urandom_range(0, 199) == 0)
          settle();
        send_request(kind, fl, t_cur, 1'b0, '0);
      end
    end
    calm = 1'b0;

    // drain, then watch for stray results
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_verdicts.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("checked %0d results from %0d items under %0d limit settings",
             results_seen, items_sent, settings_used);
    $display("saw %0d denials, %0d flow clears, %0d backward time steps",
             denials, clears, back_steps);
    if (mismatches == 0 && pending_verdicts.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
